### rtl/rkc_pkg.sv
package rkc_pkg;

	// Widths of the request and response fields.
	localparam int KEY_W = 32;
	localparam int CNT_W = 16;

	// Status codes reported with every response.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_SAT    = 2'd3;

	// Command codes.
	localparam logic CMD_INC = 1'b0;
	localparam logic CMD_DEC = 1'b1;

	typedef struct packed {
		logic             command;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic [KEY_W-1:0] max_key;
		logic [KEY_W-1:0] min_key;
		logic             table_empty;
		logic [CNT_W-1:0] key_count;
		logic [1:0]       status;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_UPDATE,
		S_RESP
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic capture;
		logic update;
	} ctl_t;

	// Datapath to controller.
	typedef struct packed {
		logic dummy_ready;
	} sts_t;

endpackage

### rtl/ranked_key_counter_unit.sv
// Sequence: a request is accepted in IDLE, the table updates in the next cycle and the
// response is offered right after that update and held until the receiver takes it.
// A new request is taken only after the previous response has left.
// Reset: arst_n clears occupancy, all counts and all keys at once; no clearing pass.
module ranked_key_counter_unit #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 32,
	parameter int COUNT_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rkc_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output rkc_pkg::rsp_t out_data
);
	import rkc_pkg::*;

	ctl_t ctl;
	sts_t sts;

	rkc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	rkc_datapath #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.req    (in_data),
		.sts    (sts),
		.rsp    (out_data)
	);

endmodule

### rtl/rkc_ctrl.sv
module rkc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  rkc_pkg::sts_t sts,
	output rkc_pkg::ctl_t ctl
);
	import rkc_pkg::*;

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state: capture, update, then hold the response.
	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		ctl.capture = 1'b0;
		ctl.update  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = sts.dummy_ready;
				if (in_valid && sts.dummy_ready) begin
					ctl.capture = 1'b1;
					state_d     = S_UPDATE;
				end
			end
			S_UPDATE: begin
				ctl.update = 1'b1;
				state_d    = S_RESP;
			end
			S_RESP: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Only one phase of work is active at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.capture && ctl.update)) else $error("capture and update together");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.capture |=> ctl.update) else $error("update did not follow capture");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.update |=> out_valid) else $error("response did not follow update");

endmodule

### rtl/rkc_datapath.sv
module rkc_datapath #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 32,
	parameter int COUNT_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  rkc_pkg::ctl_t ctl,
	input  rkc_pkg::req_t req,
	output rkc_pkg::sts_t sts,
	output rkc_pkg::rsp_t rsp
);
	import rkc_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OW = $clog2(ENTRIES + 1);
	localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

	logic [KEY_BITS-1:0]   keys_q [ENTRIES];
	logic [COUNT_BITS-1:0] cnts_q [ENTRIES];
	logic [OW-1:0]         occ_q;

	logic                  cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [ENTRIES-1:0]    hit_q;
	logic [ENTRIES-1:0]    occv;
	logic [ENTRIES-1:0]    hit_d;
	logic [KEY_BITS-1:0]   key_in;

	// Response fields.
	logic [COUNT_BITS-1:0] kc_q;
	logic [1:0]            st_q;

	assign sts.dummy_ready = 1'b1;

	// Request key at the table's key width.
	assign key_in = KEY_BITS'(req.key);

	// Occupancy mask and per-cell key match.
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			occv[i]  = (OW'(i) < occ_q);
			hit_d[i] = occv[i] && (keys_q[i] == key_in);
		end
	end

	// Match capture stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= CMD_INC;
			key_q <= '0;
			hit_q <= '0;
		end else if (ctl.capture) begin
			cmd_q <= req.command;
			key_q <= key_in;
			hit_q <= hit_d;
		end
	end

	// Broadcast values of the hit cell.
	logic                  found;
	logic [COUNT_BITS-1:0] hcnt;
	logic [COUNT_BITS-1:0] ncnt;
	logic [IW-1:0]         hpos;
	logic [IW-1:0]         tpos;
	logic                  move_up;
	logic                  move_dn;
	logic                  remove;
	logic                  append;
	logic                  sat;

	always_comb begin
		found = |hit_q;
		hcnt  = '0;
		hpos  = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (hit_q[i]) begin
				hcnt = hcnt | cnts_q[i];
				hpos = hpos | IW'(i);
			end
		end
		sat     = found && (cmd_q == CMD_INC) && (hcnt == CMAX);
		append  = !found && (cmd_q == CMD_INC) && (occ_q < OW'(ENTRIES));
		move_up = found && (cmd_q == CMD_INC) && !sat;
		remove  = found && (cmd_q == CMD_DEC) && (hcnt == COUNT_BITS'(1));
		move_dn = found && (cmd_q == CMD_DEC) && !remove;
		ncnt    = move_up ? hcnt + 1'b1 : (found && cmd_q == CMD_DEC) ? hcnt - 1'b1 : hcnt;
		tpos    = occ_q[IW-1:0];
	end

	// Target slot of the moved entry: first slot whose count is below the new
	// count (increment) or last slot whose count is above it (decrement).
	logic [ENTRIES-1:0] lt_new, gt_new;
	logic [IW-1:0]      up_t, dn_t;
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			lt_new[i] = occv[i] && (cnts_q[i] < ncnt) && (IW'(i) < hpos);
			gt_new[i] = occv[i] && (cnts_q[i] > ncnt) && (IW'(i) > hpos);
		end
		up_t = hpos;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (lt_new[i]) begin
				up_t = IW'(i);
			end
		end
		dn_t = hpos;
		for (int i = 0; i < ENTRIES; i++) begin
			if (gt_new[i]) begin
				dn_t = IW'(i);
			end
		end
	end

	// Cell array: each cell shifts, takes the moved or appended entry, clears its count or holds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				keys_q[i] <= '0;
				cnts_q[i] <= '0;
			end
		end else if (ctl.update) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (append && IW'(i) == tpos) begin
					keys_q[i] <= key_q;
					cnts_q[i] <= COUNT_BITS'(1);
				end else if (move_up && IW'(i) == up_t) begin
					keys_q[i] <= key_q;
					cnts_q[i] <= ncnt;
				end else if (move_up && IW'(i) > up_t && IW'(i) <= hpos) begin
					keys_q[i] <= keys_q[(i+ENTRIES-1) % ENTRIES];
					cnts_q[i] <= cnts_q[(i+ENTRIES-1) % ENTRIES];
				end else if (move_dn && IW'(i) == dn_t) begin
					keys_q[i] <= key_q;
					cnts_q[i] <= ncnt;
				end else if (move_dn && IW'(i) >= hpos && IW'(i) < dn_t) begin
					keys_q[i] <= keys_q[(i+1) % ENTRIES];
					cnts_q[i] <= cnts_q[(i+1) % ENTRIES];
				end else if (remove && IW'(i) >= hpos && OW'(i) + 1'b1 < occ_q) begin
					keys_q[i] <= keys_q[(i+1) % ENTRIES];
					cnts_q[i] <= cnts_q[(i+1) % ENTRIES];
				end else if (remove && OW'(i) + 1'b1 == occ_q) begin
					cnts_q[i] <= '0;
				end
			end
			if (append) begin
				occ_q <= occ_q + 1'b1;
			end else if (remove) begin
				occ_q <= occ_q - 1'b1;
			end
		end
	end

	// Result count and status, captured with the update.
	always_ff @(posedge clk) begin
		if (ctl.update) begin
			if (!found && cmd_q == CMD_DEC) begin
				kc_q <= '0;
				st_q <= ST_ABSENT;
			end else if (!found && !append) begin
				kc_q <= '0;
				st_q <= ST_FULL;
			end else if (append) begin
				kc_q <= COUNT_BITS'(1);
				st_q <= ST_OK;
			end else if (sat) begin
				kc_q <= CMAX;
				st_q <= ST_SAT;
			end else begin
				kc_q <= ncnt;
				st_q <= ST_OK;
			end
		end
	end

	// Response from the settled table.
	logic [IW-1:0] last;
	assign last = IW'(occ_q - 1'b1);
	always_comb begin
		rsp.table_empty = (occ_q == '0);
		rsp.max_key     = rsp.table_empty ? '0 : KEY_W'(keys_q[0]);
		rsp.min_key     = rsp.table_empty ? '0 : KEY_W'(keys_q[last]);
		rsp.key_count   = CNT_W'(kc_q);
		rsp.status      = st_q;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_q)) else $error("key held in two cells");
	assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OW'(ENTRIES)) else $error("occupancy overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.update && append |=> occ_q == $past(occ_q) + 1'b1) else $error("append lost");

endmodule
